@@ rtl/radix_integer_to_ascii_unit_assert.svh @@
// assertion macros used by the radix to ascii datapath
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RITA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rita assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RITA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rita assertion failed");

`endif

@@ rtl/rita_pkg.sv @@
// shared types, constants and helpers of the radix to ascii unit
`default_nettype none

package rita_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 8;
	localparam int BITS_PER_STEP  = 8;
	localparam int RADIX_MIN      = 2;
	localparam int RADIX_MAX      = 36;
	localparam int DECIMAL        = 10;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_ERR   = 8'h00;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic div_first;
		logic push;
		logic out_sign;
		logic out_digit;
		logic out_err;
	} rita_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_bad;
		logic in_neg;
		logic q_zero;
		logic last_digit;
		logic out_free;
	} rita_sts_t;

	// digit 0..35 to '0'-'9' then 'a'-'z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (dx < CHAR_W'(DECIMAL)) begin
			return CHAR_ZERO + dx;
		end else begin
			return CHAR_LOW_A + dx - CHAR_W'(DECIMAL);
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/rita_in_if.sv @@
// input channel: value, signedness and radix with valid/ready
`default_nettype none

interface rita_in_if
	import rita_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value_bits;
	logic                  is_signed;
	logic [RADIX_W-1:0]    radix;

	modport source (output valid, value_bits, is_signed, radix, input ready);
	modport sink   (input valid, value_bits, is_signed, radix, output ready);
endinterface

`default_nettype wire

@@ rtl/rita_out_if.sv @@
// output channel: one character per transaction with valid/ready
`default_nettype none

interface rita_out_if
	import rita_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;
	logic              bad_radix;

	modport source (output valid, character, last, bad_radix, input ready);
	modport sink   (input valid, character, last, bad_radix, output ready);
endinterface

`default_nettype wire

@@ rtl/rita_ctrl.sv @@
// controller state machine of the radix to ascii unit
`default_nettype none

module rita_ctrl
	import rita_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire rita_sts_t sts,
	output rita_cmd_t      cmd
);

	localparam int ITER   = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int STEP_W = (ITER > 1) ? $clog2(ITER) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_ERR  = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              neg_q, neg_d;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(ITER - 1));

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		step_d   = step_q;
		neg_d    = neg_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					neg_d    = sts.in_neg;
					step_d   = '0;
					state_d  = sts.in_bad ? ST_ERR : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (step_q == '0);
				if (last_step) begin
					cmd.push = 1'b1;
					step_d   = '0;
					if (sts.q_zero) begin
						state_d = neg_q ? ST_SIGN : ST_EMIT;
					end
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					cmd.out_sign = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_digit = 1'b1;
					if (sts.last_digit) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (sts.out_free) begin
					cmd.out_err = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			neg_q   <= neg_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/rita_datapath.sv @@
// datapath: shared divider, digit stack and output register
`default_nettype none

`include "radix_integer_to_ascii_unit_assert.svh"

module rita_datapath
	import rita_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [VALUE_BITS-1:0] value_bits,
	input  wire logic                  is_signed,
	input  wire logic [RADIX_W-1:0]    radix,
	input  wire rita_cmd_t             cmd,
	output rita_sts_t                  sts,
	output logic                       out_valid,
	output logic [CHAR_W-1:0]          out_character,
	output logic                       out_last,
	output logic                       out_bad,
	input  wire logic                  out_ready
);

	localparam int ITER  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int DV_W  = ITER * BITS_PER_STEP;
	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [DV_W-1:0]          dv_q, dv_next;
	logic [DIGIT_W-1:0]       rem_q, rem_c;
	logic [RADIX_W-1:0]       radix_q;
	logic [BITS_PER_STEP-1:0] top_bits, qbits;
	logic [DIGIT_W:0]         trial, diff;
	logic [DIGIT_W-1:0]       stk_q [VALUE_BITS];
	logic [CNT_W-1:0]         cnt_q;
	logic [VALUE_BITS-1:0]    mag;
	logic                     out_valid_q;
	logic [CHAR_W-1:0]        char_q;
	logic                     last_q;
	logic                     bad_q;

	// input decode
	assign sts.in_bad = (radix < RADIX_W'(RADIX_MIN)) || (radix > RADIX_W'(RADIX_MAX));
	assign sts.in_neg = is_signed && (radix == RADIX_W'(DECIMAL)) && value_bits[VALUE_BITS-1];
	assign mag = sts.in_neg ? (~value_bits + VALUE_BITS'(1)) : value_bits;

	// one byte of restoring division per cycle, quotient bits shift into dv_q
	assign top_bits = dv_q[DV_W-1 -: BITS_PER_STEP];

	always_comb begin
		rem_c = cmd.div_first ? '0 : rem_q;
		qbits = '0;
		trial = '0;
		diff  = '0;
		for (int i = BITS_PER_STEP - 1; i >= 0; i--) begin
			trial = {rem_c, top_bits[i]};
			diff  = trial - {1'b0, radix_q};
			if (trial >= {1'b0, radix_q}) begin
				rem_c    = diff[DIGIT_W-1:0];
				qbits[i] = 1'b1;
			end else begin
				rem_c = trial[DIGIT_W-1:0];
			end
		end
	end

	assign dv_next = (dv_q << BITS_PER_STEP) | DV_W'(qbits);

	assign sts.q_zero     = (dv_next == '0);
	assign sts.last_digit = (cnt_q == CNT_W'(1));
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dv_q    <= DV_W'(mag);
			radix_q <= radix;
		end else if (cmd.div_step) begin
			dv_q  <= dv_next;
			rem_q <= rem_c;
		end
	end

	// digit stack: digits arrive least significant first, leave from the top
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_q[0] <= rem_c;
			for (int i = 1; i < VALUE_BITS; i++) begin
				stk_q[i] <= stk_q[i-1];
			end
		end else if (cmd.out_digit) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				stk_q[i] <= stk_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.out_digit) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_err || cmd.out_sign || cmd.out_digit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_err) begin
			char_q <= CHAR_ERR;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end else if (cmd.out_sign) begin
			char_q <= MINUS_CHAR;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.out_digit) begin
			char_q <= digit_char(stk_q[0]);
			last_q <= sts.last_digit;
			bad_q  <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_character = char_q;
	assign out_last      = last_q;
	assign out_bad       = bad_q;

	`RITA_ASSERT_IMP(a_push_room, cmd.push, cnt_q < CNT_W'(VALUE_BITS))
	`RITA_ASSERT_IMP(a_pop_nonempty, cmd.out_digit, cnt_q != '0)
	`RITA_ASSERT_IMP(a_out_free, cmd.out_err || cmd.out_sign || cmd.out_digit, sts.out_free)
	`RITA_ASSERT_IMP(a_rem_below_radix, cmd.div_step && !cmd.div_first, rem_q < radix_q)
	`RITA_ASSERT_NXT(a_load_clears, cmd.load, cnt_q == '0)

endmodule

`default_nettype wire

@@ rtl/radix_integer_to_ascii_unit.sv @@
// sequence: accept, then each digit from the shared divider a byte at a time,
//   then each character into the output register
// one conversion at a time: the next input waits until the controller is idle again
// bad radix: one error transaction after accept, issued from the error state
// reset: arst_n clears controller state, digit count and output valid; no clearing pass
`default_nettype none

module radix_integer_to_ascii_unit
	import rita_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rita_in_if.sink    din,
	rita_out_if.source dout
);

	rita_cmd_t cmd;
	rita_sts_t sts;
	logic      in_ready;

	// input transaction accepted only while the controller is idle
	assign din.ready = in_ready;

	// controller: idle, divide loop, sign, emit, error
	rita_ctrl #(
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: byte-per-cycle divider by the radix, digit stack, output register
	rita_datapath #(
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.value_bits    (din.value_bits),
		.is_signed     (din.is_signed),
		.radix         (din.radix),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (dout.valid),
		.out_character (dout.character),
		.out_last      (dout.last),
		.out_bad       (dout.bad_radix),
		.out_ready     (dout.ready)
	);

endmodule

`default_nettype wire
